// ===== rtl/tevq_pkg.sv =====
// Shared types, codes and constants of the throttled event queue.
package tevq_pkg;

  localparam int TIME_W     = 32;
  localparam int SEQ_W      = 32;
  localparam int EV_IN_W    = 8;
  localparam int EV_OUT_W   = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int ENTRY_W    = SEQ_W + EV_OUT_W;

  localparam int EVENT_COUNT_DEF = 32;
  localparam int RING_DEPTH_DEF  = 16;

  localparam logic [TIME_W-1:0]   COOLDOWN_RST = 32'd1000;
  localparam logic [TIME_W-1:0]   GAP_RST      = 32'd250;
  localparam logic [EV_OUT_W-1:0] PRIO_RST     = 5'd12;
  localparam logic [31:0]         MASK_RST     = 32'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 8'd3;

  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_POP     = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_BAD_INDEX  = 3'd1,
    ST_UNASSIGNED = 3'd2,
    ST_COOLDOWN   = 3'd3,
    ST_GAP        = 3'd4,
    ST_FULL       = 3'd5,
    ST_POPPED     = 3'd6,
    ST_EMPTY      = 3'd7
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// ===== rtl/tevq_if.sv =====
// Handshake channels of the throttled event queue: command, result and configuration.
interface tevq_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [tevq_pkg::EV_IN_W-1:0]  event_index;
  logic [tevq_pkg::TIME_W-1:0]   time_now;
  logic                          bypass;

  modport source (output valid, command, event_index, time_now, bypass, input ready);
  modport sink   (input valid, command, event_index, time_now, bypass, output ready);
endinterface

interface tevq_res_if;
  logic                          valid;
  logic                          ready;
  tevq_pkg::status_t             status;
  logic                          out_valid;
  logic [tevq_pkg::SEQ_W-1:0]    out_sequence;
  logic [tevq_pkg::EV_OUT_W-1:0] out_event;

  modport source (output valid, status, out_valid, out_sequence, out_event, input ready);
  modport sink   (input valid, status, out_valid, out_sequence, out_event, output ready);
endinterface

interface tevq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tevq_pkg::CFG_IDX_W-1:0]  index;
  logic [tevq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/throttled_event_queue.sv =====
// Throttled event queue: rate-limited event triggers feeding a ring of queued entries.
//
// Usage: every word on the cmd channel is either a trigger (command 0) or a pop
// (command 1), and each produces exactly one word on the res channel. A trigger
// is checked for a legal index, an assigned clip, the per-event cooldown and the
// global gap (both skipped with bypass or for the priority event), then queued
// unless the ring already holds RING_DEPTH-1 entries. A pop returns the oldest
// entry or reports the ring empty. The cfg channel is ready whenever reset is low;
// the user writes configuration on it only while no command is in flight (unchecked).
//
// Sequence: a command accepted in idle is captured along with the reads of the
// timing table and ring memories; in the exec state it is decided, written back
// and its result loaded into the output register on res. The block handles one
// command at a time and takes no new command until the exec state is done, as
// the memories are read on accept and written back from the exec state.
// A result waiting on a stalled receiver sits in the output register; the next
// command is still accepted, but its write-back waits until that result is taken.
//
// Reset (synchronous, active high) clears the pointers, the sequence counter,
// the last-any time and the per-event valid bits of the timing table, and loads
// the configuration defaults. The ring contents are not cleared. Neither the cmd
// nor the cfg channel is ready while reset is high.
module throttled_event_queue #(
  parameter int EVENT_COUNT = tevq_pkg::EVENT_COUNT_DEF,
  parameter int RING_DEPTH  = tevq_pkg::RING_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  tevq_cfg_if.sink  cfg,
  tevq_cmd_if.sink  cmd,
  tevq_res_if.source res
);
  import tevq_pkg::*;

  localparam int EV_W  = $clog2(EVENT_COUNT);
  localparam int PTR_W = $clog2(RING_DEPTH);

  // Configuration registers.
  logic [TIME_W-1:0]   cooldown;
  logic [TIME_W-1:0]   gap;
  logic [EV_OUT_W-1:0] prio;
  logic [31:0]         mask;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown <= COOLDOWN_RST;
      gap      <= GAP_RST;
      prio     <= PRIO_RST;
      mask     <= MASK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COOLDOWN: cooldown <= cfg.data;
        CFG_GAP:      gap      <= cfg.data;
        CFG_PRIO:     prio     <= cfg.data[EV_OUT_W-1:0];
        CFG_MASK:     mask     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer: accept in idle, decide and write back in exec.
  state_t state;
  state_t state_next;
  logic   cmd_acc;
  logic   exec_fire;

  assign cmd_acc = cmd.valid && cmd.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_acc) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == S_IDLE) && !rst;
    exec_fire = (state == S_EXEC) && (!res.valid || res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured command.
  logic                command_q;
  logic [EV_IN_W-1:0]  ev_q;
  logic [TIME_W-1:0]   now_q;
  logic                bypass_q;

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      command_q <= cmd.command;
      ev_q      <= cmd.event_index;
      now_q     <= cmd.time_now;
      bypass_q  <= cmd.bypass;
    end
  end

  // Queue pointers and counters.
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  rp_next;
  logic [SEQ_W-1:0]  seq;
  logic [TIME_W-1:0] last_any;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wp_next = adv(wp);
  assign rp_next = adv(rp);

  // Timing table: memory with one valid bit per event, cleared at reset.
  logic [TIME_W-1:0]      fire_mem [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] fire_vld;
  logic [TIME_W-1:0]      fire_rd;
  logic                   fire_vld_rd;
  logic                   cmd_in_range;
  logic [EV_W-1:0]        cmd_ev_idx;

  assign cmd_in_range = cmd.event_index < EV_IN_W'(EVENT_COUNT);
  assign cmd_ev_idx   = cmd.event_index[EV_W-1:0];

  // Ring memory: sequence number and event index per entry.
  logic [ENTRY_W-1:0] ring_mem [RING_DEPTH];
  logic [ENTRY_W-1:0] ring_rd;

  // Decision for the captured command.
  logic              ev_bad;
  logic              ev_unassigned;
  logic              exempt;
  logic              cool_hit;
  logic              gap_hit;
  logic [TIME_W-1:0] cool_delta;
  logic [TIME_W-1:0] gap_delta;
  logic [TIME_W-1:0] stamp;
  status_t           status_d;

  assign cool_delta = now_q - fire_rd;
  assign gap_delta  = now_q - last_any;
  assign stamp      = (now_q != '0) ? now_q : TIME_W'(1);

  always_comb begin
    ev_bad        = ev_q >= EV_IN_W'(EVENT_COUNT);
    ev_unassigned = (ev_q >= EV_IN_W'(32)) || !mask[ev_q[EV_OUT_W-1:0]];
    exempt        = bypass_q || (ev_q == {{(EV_IN_W - EV_OUT_W){1'b0}}, prio});
    cool_hit      = fire_vld_rd && (cool_delta < cooldown);
    gap_hit       = (last_any != '0) && (gap_delta < gap);
    if (command_q == CMD_POP) begin
      status_d = (rp == wp) ? ST_EMPTY : ST_POPPED;
    end else if (ev_bad) begin
      status_d = ST_BAD_INDEX;
    end else if (ev_unassigned) begin
      status_d = ST_UNASSIGNED;
    end else if (!exempt && cool_hit) begin
      status_d = ST_COOLDOWN;
    end else if (!exempt && gap_hit) begin
      status_d = ST_GAP;
    end else if (wp_next == rp) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_QUEUED;
    end
  end

  logic do_queue;
  logic do_pop;

  assign do_queue = exec_fire && (status_d == ST_QUEUED);
  assign do_pop   = exec_fire && (status_d == ST_POPPED);

  // Memory reads on accept; write-back from the exec cycle. The write of one
  // command always lands before the next command's read, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      if (cmd_in_range) begin
        fire_rd     <= fire_mem[cmd_ev_idx];
        fire_vld_rd <= fire_vld[cmd_ev_idx];
      end else begin
        fire_rd     <= '0;
        fire_vld_rd <= 1'b0;
      end
      ring_rd <= ring_mem[rp];
    end
    if (do_queue) begin
      fire_mem[ev_q[EV_W-1:0]] <= stamp;
      ring_mem[wp]             <= {seq + SEQ_W'(1), ev_q[EV_OUT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_vld <= '0;
      wp       <= '0;
      rp       <= '0;
      seq      <= '0;
      last_any <= '0;
    end else begin
      if (do_queue) begin
        fire_vld[ev_q[EV_W-1:0]] <= 1'b1;
        wp       <= wp_next;
        seq      <= seq + SEQ_W'(1);
        last_any <= stamp;
      end
      if (do_pop) begin
        rp <= rp_next;
      end
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (exec_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res.status <= status_d;
      if (status_d == ST_POPPED) begin
        res.out_valid    <= 1'b1;
        res.out_sequence <= ring_rd[ENTRY_W-1:EV_OUT_W];
        res.out_event    <= ring_rd[EV_OUT_W-1:0];
      end else begin
        res.out_valid    <= 1'b0;
        res.out_sequence <= '0;
        res.out_event    <= '0;
      end
    end
  end

  // A queued entry never makes the ring look empty.
  a_queue_not_empty: assert property (@(posedge clk) disable iff (rst)
    do_queue |=> (wp != rp))
    else $error("ring overran after a queued trigger");

  // A pop is only reported when the ring held an entry.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> (rp != wp))
    else $error("pop reported on an empty ring");

  // Rejected triggers and empty pops leave the pointers alone.
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && !do_queue && !do_pop) |=> ($stable(wp) && $stable(rp)))
    else $error("pointer moved on a rejected command");

  // The entry flag of a result goes only with a popped status.
  a_out_valid_popped: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.out_valid) |-> (res.status == ST_POPPED))
    else $error("entry delivered without popped status");

endmodule

// ===== dv/tb_throttled_event_queue.sv =====
// Self-checking testbench of the throttled event queue: directed table, then random phases.
`timescale 1ns / 100ps

module tb_throttled_event_queue;
  import tevq_pkg::*;

  localparam int RPTR_W = $clog2(RING_DEPTH_DEF);

  // One result word as the res channel carries it.
  typedef struct packed {
    status_t             status;
    logic                out_valid;
    logic [SEQ_W-1:0]    out_sequence;
    logic [EV_OUT_W-1:0] out_event;
  } result_t;

  // One row of the directed table: either a register write or a command word
  // repeated reps times. Where typed is set, want is the result read straight
  // off the spec; otherwise the predictor supplies the expectation.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  command;
    logic [EV_IN_W-1:0]    event_index;
    logic [TIME_W-1:0]     time_now;
    logic                  bypass;
    int                    reps;
    bit                    typed;
    result_t               want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tevq_cfg_if cfg_if ();
  tevq_cmd_if cmd_if ();
  tevq_res_if res_if ();

  throttled_event_queue u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .res (res_if)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("throttled_event_queue regression: fail");
    $finish;
  end

  // Predictor state: configuration copy, timing table, ring and pointers.
  logic [TIME_W-1:0]   cooldown_reg;
  logic [TIME_W-1:0]   gap_reg;
  logic [EV_OUT_W-1:0] prio_reg;
  logic [31:0]         mask_reg;
  logic [TIME_W-1:0]   fire_stamp [EVENT_COUNT_DEF];
  logic [TIME_W-1:0]   any_stamp;
  logic [SEQ_W-1:0]    ring_seq [RING_DEPTH_DEF];
  logic [EV_OUT_W-1:0] ring_ev [RING_DEPTH_DEF];
  logic [RPTR_W-1:0]   ring_wr;
  logic [RPTR_W-1:0]   ring_rd;
  logic [SEQ_W-1:0]    seq_count;

  // Results owed by the block, oldest first.
  result_t expected_results [$];
  dir_row_t dir_rows [$];

  int send_idle_pct = 28;
  int recv_idle_pct = 55;
  int mismatch_count = 0;
  int words_sent = 0;
  int results_seen = 0;
  int status_seen [8];
  logic [TIME_W-1:0] clock_ms;

  // Works out the result of one command word and advances the predictor.
  // Triggers are screened in the order of the spec: index range, clip mask,
  // then cooldown and gap (unless forced or the priority event), then room
  // in the ring. The ring keeps one slot free, so it holds RING_DEPTH-1.
  function automatic result_t predict_queue_step(input logic c,
                                                 input logic [EV_IN_W-1:0] ev,
                                                 input logic [TIME_W-1:0] now,
                                                 input logic byp);
    result_t           r;
    logic [TIME_W-1:0] since_fire;
    logic [TIME_W-1:0] since_any;
    logic              screened;
    logic [RPTR_W-1:0] nxt;
    r.status       = ST_QUEUED;
    r.out_valid    = 1'b0;
    r.out_sequence = '0;
    r.out_event    = '0;
    if (c == CMD_POP) begin
      if (ring_rd == ring_wr) begin
        r.status = ST_EMPTY;
      end else begin
        r.status       = ST_POPPED;
        r.out_valid    = 1'b1;
        r.out_sequence = ring_seq[ring_rd];
        r.out_event    = ring_ev[ring_rd];
        ring_rd        = RPTR_W'((ring_rd + 1) % RING_DEPTH_DEF);
      end
    end else begin
      since_fire = now - fire_stamp[ev[EV_OUT_W-1:0]];
      since_any  = now - any_stamp;
      screened   = !byp && (ev != prio_reg);
      nxt        = RPTR_W'((ring_wr + 1) % RING_DEPTH_DEF);
      if (ev >= EVENT_COUNT_DEF) begin
        r.status = ST_BAD_INDEX;
      end else if (ev >= 32 || !mask_reg[ev[4:0]]) begin
        r.status = ST_UNASSIGNED;
      end else if (screened && fire_stamp[ev[EV_OUT_W-1:0]] != '0 &&
                   since_fire < cooldown_reg) begin
        // A zero stamp means the event never fired, so no cooldown applies.
        r.status = ST_COOLDOWN;
      end else if (screened && any_stamp != '0 && since_any < gap_reg) begin
        r.status = ST_GAP;
      end else if (nxt == ring_rd) begin
        // Dropped on a full ring: nothing is recorded, not even the time.
        r.status = ST_FULL;
      end else begin
        seq_count         = seq_count + 1'b1;
        ring_seq[ring_wr] = seq_count;
        ring_ev[ring_wr]  = ev[EV_OUT_W-1:0];
        ring_wr           = nxt;
        // Time zero is stored as one so that it never reads as never fired.
        fire_stamp[ev[EV_OUT_W-1:0]] = (now != '0) ? now : 32'd1;
        any_stamp                    = (now != '0) ? now : 32'd1;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t op_row(input logic c, input logic [EV_IN_W-1:0] ev,
                                      input logic [TIME_W-1:0] t, input logic byp,
                                      input int reps, input bit typed,
                                      input status_t st, input logic [SEQ_W-1:0] seq,
                                      input logic [EV_OUT_W-1:0] e);
    dir_row_t row;
    row.is_cfg                = 1'b0;
    row.cfg_idx               = '0;
    row.cfg_data              = '0;
    row.command               = c;
    row.event_index           = ev;
    row.time_now              = t;
    row.bypass                = byp;
    row.reps                  = reps;
    row.typed                 = typed;
    row.want.status           = st;
    row.want.out_valid        = (st == ST_POPPED);
    row.want.out_sequence     = seq;
    row.want.out_event        = e;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row        = op_row(CMD_TRIGGER, '0, '0, 1'b0, 0, 1'b0, ST_QUEUED, '0, '0);
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    return row;
  endfunction

  // Lowers the command valid and waits until every owed result has been
  // taken, then lets the two-stage pipeline settle.
  task automatic hold_until_drained();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only happen with the block idle. The predictor's copy
  // is updated at the same edge the block takes the word.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    hold_until_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_COOLDOWN: cooldown_reg = data;
      CFG_GAP:      gap_reg      = data;
      CFG_PRIO:     prio_reg     = data[EV_OUT_W-1:0];
      CFG_MASK:     mask_reg     = data;
      default:      ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Presents one command word, with random idle cycles ahead of it, and
  // files the expected result once the block accepts the word. Valid stays
  // high after acceptance; the next call either idles it or drives the
  // next word at the following falling edge.
  task automatic drive_word(input logic c, input logic [EV_IN_W-1:0] ev,
                            input logic [TIME_W-1:0] t, input logic byp,
                            input bit typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.command     = c;
    cmd_if.event_index = ev;
    cmd_if.time_now    = t;
    cmd_if.bypass      = byp;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = predict_queue_step(c, ev, t, byp);
    expected_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Random traffic comes in bursts of triggers or of pops, so that the ring
  // swings between full and empty. Most triggers name a legal event and a
  // time that creeps forward, so cooldown and gap decisions land on both
  // sides; the rest draw any 8-bit index or jump to a random time.
  task automatic run_random_phase(input int n_words, input int step_max);
    int               sent;
    int               burst_len;
    bit               trig_burst;
    logic             c;
    logic [EV_IN_W-1:0] ev;
    logic             byp;
    result_t          none;
    none = '0;
    sent = 0;
    while (sent < n_words) begin
      trig_burst = ($urandom_range(0, 99) < 55);
      burst_len  = $urandom_range(1, 18);
      for (int k = 0; k < burst_len && sent < n_words; k++) begin
        // Midway through, stop sending until the block has caught up.
        if (sent == n_words / 2) hold_until_drained();
        c   = trig_burst ? CMD_TRIGGER : CMD_POP;
        ev  = ($urandom_range(0, 99) < 88) ? EV_IN_W'($urandom_range(0, EVENT_COUNT_DEF - 1))
                                           : EV_IN_W'($urandom_range(0, 255));
        byp = ($urandom_range(0, 99) < 20);
        if ($urandom_range(0, 99) < 90) begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
        end else begin
          clock_ms = $urandom;
        end
        drive_word(c, ev, clock_ms, byp, 1'b0, none);
        sent++;
      end
    end
  endtask

  // Receiver side: ready toggles at random at the falling edge.
  always @(negedge clk) begin
    res_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Every result word taken by the receiver is held against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      status_seen[res_if.status]++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d", res_if.status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_if.status);
          mismatch_count++;
        end
        if (res_if.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, actual %0d", want.out_valid, res_if.out_valid);
          mismatch_count++;
        end
        if (res_if.out_sequence !== want.out_sequence) begin
          $error("out_sequence: expected %0d, actual %0d",
                 want.out_sequence, res_if.out_sequence);
          mismatch_count++;
        end
        if (res_if.out_event !== want.out_event) begin
          $error("out_event: expected %0d, actual %0d", want.out_event, res_if.out_event);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_TRIGGER;
    cmd_if.event_index = '0;
    cmd_if.time_now    = '0;
    cmd_if.bypass      = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Predictor starts from the reset state of the block.
    cooldown_reg = COOLDOWN_RST;
    gap_reg      = GAP_RST;
    prio_reg     = PRIO_RST;
    mask_reg     = MASK_RST;
    foreach (fire_stamp[i]) fire_stamp[i] = '0;
    foreach (ring_seq[i]) begin
      ring_seq[i] = '0;
      ring_ev[i]  = '0;
    end
    any_stamp = '0;
    ring_wr   = '0;
    ring_rd   = '0;
    seq_count = '0;
    clock_ms  = '0;

    // Directed table. With the reset mask nothing is assigned, so the first
    // triggers can only fail the index or the mask check.
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_EMPTY, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_UNASSIGNED, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd255, 32'd0, 1'b0, 1, 1'b1, ST_BAD_INDEX, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd32, 32'd0, 1'b1, 1, 1'b1, ST_BAD_INDEX, 0, 0));
    dir_rows.push_back(cfg_row(CFG_MASK, 32'hFFFF_FFFF));
    // First firing ever, at time zero: no cooldown or gap yet, stored as one.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_QUEUED, 0, 0));
    // Event 1 never fired, but the global gap since event 0 has not passed.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd1, 32'd100, 1'b0, 1, 1'b1, ST_GAP, 0, 0));
    // Event 0 again before its cooldown has passed.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd0, 32'd500, 1'b0, 1, 1'b1, ST_COOLDOWN, 0, 0));
    // The priority event and a forced trigger both skip the timing checks.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd12, 32'd2, 1'b0, 1, 1'b1, ST_QUEUED, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd31, 32'd3, 1'b1, 1, 1'b1, ST_QUEUED, 0, 0));
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_POPPED, 1, 0));
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_POPPED, 2, 12));
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_POPPED, 3, 31));
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 1, 1'b1, ST_EMPTY, 0, 0));
    // Largest time, then a small time just past the wrap: the gap is
    // measured modulo 2^32 and has not passed.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd5, 32'hFFFF_FFFF, 1'b0, 1, 1'b0,
                              ST_QUEUED, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd6, 32'd100, 1'b0, 1, 1'b0, ST_QUEUED, 0, 0));
    dir_rows.push_back(cfg_row(CFG_PRIO, 32'd0));
    dir_rows.push_back(cfg_row(CFG_COOLDOWN, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_GAP, 32'hFFFF_FFFF));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd0, 32'd200, 1'b0, 1, 1'b0, ST_QUEUED, 0, 0));
    // Forced triggers fill the ring to its capacity of depth minus one; the
    // next one is dropped as full.
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd7, 32'd0, 1'b1, 13, 1'b0, ST_QUEUED, 0, 0));
    dir_rows.push_back(op_row(CMD_TRIGGER, 8'd8, 32'd9, 1'b1, 1, 1'b1, ST_FULL, 0, 0));
    dir_rows.push_back(op_row(CMD_POP, 8'd0, 32'd0, 1'b0, 2, 1'b0, ST_QUEUED, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part runs under the first idling regime.
    send_idle_pct = 28;
    recv_idle_pct = 55;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_register(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        repeat (dir_rows[i].reps)
          drive_word(dir_rows[i].command, dir_rows[i].event_index, dir_rows[i].time_now,
                     dir_rows[i].bypass, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Phase one: short random cooldown and gap, random mask and priority;
    // sender idles lightly, receiver stalls often.
    write_register(CFG_COOLDOWN, $urandom_range(0, 80));
    write_register(CFG_GAP, $urandom_range(0, 30));
    write_register(CFG_PRIO, $urandom_range(0, 31));
    write_register(CFG_MASK, $urandom);
    run_random_phase(134, 40);

    // Phase two: no timing limits, every clip assigned, top priority index;
    // the idling regimes swap.
    send_idle_pct = 55;
    recv_idle_pct = 28;
    write_register(CFG_COOLDOWN, 32'd0);
    write_register(CFG_GAP, 32'd0);
    write_register(CFG_PRIO, 32'd31);
    write_register(CFG_MASK, 32'hFFFF_FFFF);
    run_random_phase(134, 10);

    // Phase three: long cooldown against a short gap, back to back on both
    // sides with no idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CFG_COOLDOWN, $urandom_range(100, 400));
    write_register(CFG_GAP, $urandom_range(0, 60));
    write_register(CFG_PRIO, $urandom_range(0, 31));
    write_register(CFG_MASK, $urandom | 32'h1);
    run_random_phase(134, 30);

    // Let the last results drain and give the pipeline time to settle.
    hold_until_drained();
    repeat (6) @(posedge clk);

    $display("Run covered %0d command words and %0d results under three idling regimes.",
             words_sent, results_seen);
    $display("Queued %0d, popped %0d, empty %0d, full %0d, cooldown %0d, gap %0d, rejected %0d.",
             status_seen[ST_QUEUED], status_seen[ST_POPPED], status_seen[ST_EMPTY],
             status_seen[ST_FULL], status_seen[ST_COOLDOWN], status_seen[ST_GAP],
             status_seen[ST_BAD_INDEX] + status_seen[ST_UNASSIGNED]);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("throttled_event_queue regression: pass");
    end else begin
      $display("throttled_event_queue regression: fail");
    end
    $finish;
  end

endmodule
